/* rtl/bcpd_pkg.sv */
package bcpd_pkg;

  localparam int BUS_SAMPLE_W = 12;
  localparam int VOLT_W       = 16;
  localparam int COMPARE_W    = 16;
  localparam int BUS_W        = 24;
  localparam int CFG_DATA_W   = 16;
  localparam int CFG_INDEX_W  = 2;

  // serial multiplier / divider datapath
  localparam int MUL_A_W    = 17;
  localparam int MUL_B_W    = 25;
  localparam int PROD_W     = MUL_A_W + MUL_B_W;
  localparam int STEPS      = MUL_A_W;
  localparam int STEP_CNT_W = $clog2(STEPS);

  localparam logic [CFG_INDEX_W-1:0] REG_FILTER_ALPHA  = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_BUS_COEFF     = 2'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_PWM_PERIOD    = 2'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_REVERSE_ORDER = 2'd3;

  localparam logic [8:0]       ALPHA_RESET   = 9'd128;
  localparam logic [8:0]       ALPHA_ONE     = 9'd256;
  localparam logic [15:0]      COEFF_RESET   = 16'd4096;
  localparam logic [15:0]      PERIOD_RESET  = 16'd4249;
  localparam logic [BUS_W-1:0] BUS_RESET     = 24'd3072000;
  localparam logic [BUS_W-1:0] BUS_MAX       = 24'hFFFFFF;

  // duty ratios fed through the shared mul/div: 1/50, 49/50 and 1/2
  localparam logic [MUL_B_W-1:0] CLAMP_DEN   = 25'd50;
  localparam logic [MUL_B_W-1:0] CLAMP_LO_NUM = 25'd1;
  localparam logic [MUL_B_W-1:0] CLAMP_HI_NUM = 25'd49;
  localparam logic [MUL_B_W-1:0] HALF_NUM    = 25'd1;
  localparam logic [MUL_B_W-1:0] HALF_DEN    = 25'd2;

  localparam logic [1:0] PH_A    = 2'd0;
  localparam logic [1:0] PH_B    = 2'd1;
  localparam logic [1:0] PH_LAST = 2'd2;

  typedef struct packed {
    logic                     mode;
    logic [BUS_SAMPLE_W-1:0]  bus_sample;
    logic signed [VOLT_W-1:0] volt_a;
    logic signed [VOLT_W-1:0] volt_b;
    logic signed [VOLT_W-1:0] volt_c;
  } in_item_t;

  typedef struct packed {
    logic [COMPARE_W-1:0] compare_ch1;
    logic [COMPARE_W-1:0] compare_ch2;
    logic [COMPARE_W-1:0] compare_ch3;
  } out_item_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_BUS_GO,
    S_BUS_WAIT,
    S_FILT_GO,
    S_FILT_WAIT,
    S_FILT_ADD,
    S_PH_PREP,
    S_PH_SCALE,
    S_PH_CLAMP,
    S_PH_MUL_WAIT,
    S_PH_DIV_WAIT,
    S_OUT
  } state_t;

endpackage

/* rtl/bcpd_serial_mul.sv */
module bcpd_serial_mul (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         start,
  input  logic [bcpd_pkg::MUL_A_W-1:0] a,
  input  logic [bcpd_pkg::MUL_B_W-1:0] b,
  output logic [bcpd_pkg::PROD_W-1:0]  prod,
  output logic                         done
);
  import bcpd_pkg::*;

  logic [MUL_B_W:0]    hi;
  logic [MUL_A_W-1:0]  lo;
  logic [MUL_B_W-1:0]  mcand;
  logic [STEP_CNT_W-1:0] cnt;
  logic                busy;
  logic [MUL_B_W:0]    sum;

  // one multiplier bit per cycle, lsb first, product shifts right
  assign sum  = hi + (lo[0] ? {1'b0, mcand} : '0);
  assign prod = {hi[MUL_B_W-1:0], lo};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 1'b1;
        if (cnt == STEP_CNT_W'(STEPS - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      hi    <= '0;
      lo    <= a;
      mcand <= b;
    end else if (busy) begin
      hi <= {1'b0, sum[MUL_B_W:1]};
      lo <= {sum[0], lo[MUL_A_W-1:1]};
    end
  end

endmodule

/* rtl/bcpd_serial_div.sv */
module bcpd_serial_div (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         start,
  input  logic [bcpd_pkg::PROD_W-1:0]  dividend,
  input  logic [bcpd_pkg::MUL_B_W-1:0] divisor,
  output logic [bcpd_pkg::MUL_A_W-1:0] quotient,
  output logic                         done
);
  import bcpd_pkg::*;

  logic [MUL_B_W-1:0]    rem;
  logic [MUL_A_W-1:0]    dq;
  logic [MUL_B_W-1:0]    dsor;
  logic [STEP_CNT_W-1:0] cnt;
  logic                  busy;
  logic [MUL_B_W:0]      trial;
  logic [MUL_B_W:0]      trial_sub;
  logic                  ge;

  // quotient fits in MUL_A_W bits, so the upper dividend bits start below the divisor
  assign trial     = {rem, dq[MUL_A_W-1]};
  assign ge        = trial >= {1'b0, dsor};
  assign trial_sub = trial - {1'b0, dsor};
  assign quotient  = dq;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 1'b1;
        if (cnt == STEP_CNT_W'(STEPS - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem  <= dividend[PROD_W-1:MUL_A_W];
      dq   <= dividend[MUL_A_W-1:0];
      dsor <= divisor;
    end else if (busy) begin
      rem <= ge ? trial_sub[MUL_B_W-1:0] : trial[MUL_B_W-1:0];
      dq  <= {dq[MUL_A_W-2:0], ge};
    end
  end

endmodule

/* rtl/bus_compensated_pwm_duty.sv */
// Bus-compensated three-phase PWM duty: a mode 0 request filters a bus ADC sample into the
// bus voltage estimate and returns nothing; a mode 1 request turns three phase voltages into
// three timer compares, duty 0.5*(v/vbus+1) clamped to 2..98 % of period+1. One request is
// in work at a time. A bus sample uses one 17-step bit-serial multiplier, and a voltage
// command uses it together with one 17-step restoring divider; the three phases share both
// in turn. A finished result waits in the output register while the next request is
// taken.
module bus_compensated_pwm_duty #(
  parameter int ADC_BITS = 12
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  bcpd_pkg::in_item_t               in_item,
  output logic                             out_valid,
  input  logic                             out_ready,
  output bcpd_pkg::out_item_t              out_item,
  input  logic                             cfg_we,
  input  logic [bcpd_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [bcpd_pkg::CFG_DATA_W-1:0]  cfg_data
);
  import bcpd_pkg::*;

  state_t state, state_next;

  logic [8:0]       filter_alpha;
  logic [15:0]      bus_coeff;
  logic [15:0]      pwm_period;
  logic             reverse_order;
  logic [BUS_W-1:0] bus_est;

  in_item_t             item;
  logic [1:0]           ph;
  logic [COMPARE_W-1:0] comp_a, comp_b, comp_c;
  logic [BUS_W-1:0]     target;
  logic                 diff_neg;
  logic signed [33:0]   filt_p;
  logic signed [25:0]   num_q;
  logic signed [31:0]   n50;
  logic [30:0]          d49;
  logic [MUL_B_W-1:0]   den_sel;

  logic                 mul_start, mul_done, div_start, div_done;
  logic [MUL_A_W-1:0]   mul_a;
  logic [MUL_B_W-1:0]   mul_b;
  logic [PROD_W-1:0]    mul_prod;
  logic [MUL_A_W-1:0]   div_quo;

  logic [BUS_SAMPLE_W-1:0] sample_m;
  logic [8:0]              alpha_c;
  logic [MUL_A_W-1:0]      scale;
  logic signed [VOLT_W-1:0] v_cur;
  logic signed [25:0]      num_next;
  logic signed [31:0]      n_ext;
  logic [30:0]             e_ext;
  logic [MUL_B_W-1:0]      den_full;
  logic [MUL_B_W-1:0]      num_sel;
  logic [MUL_B_W-1:0]      den_sel_next;
  logic                    diff_neg_c;
  logic [BUS_W-1:0]        diff_mag;
  logic signed [33:0]      step;
  logic signed [34:0]      est_sum;
  logic [BUS_W-1:0]        est_next;
  logic                    out_free;

  bcpd_serial_mul u_mul (
    .clk   (clk),
    .rst   (rst),
    .start (mul_start),
    .a     (mul_a),
    .b     (mul_b),
    .prod  (mul_prod),
    .done  (mul_done)
  );

  bcpd_serial_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (mul_prod),
    .divisor  (den_sel),
    .quotient (div_quo),
    .done     (div_done)
  );

  always_comb begin
    for (int i = 0; i < BUS_SAMPLE_W; i++) begin
      sample_m[i] = item.bus_sample[i] & (i < ADC_BITS);
    end
  end

  assign alpha_c  = (filter_alpha > ALPHA_ONE) ? ALPHA_ONE : filter_alpha;
  assign scale    = {1'b0, pwm_period} + MUL_A_W'(1);
  assign in_ready = (state == S_IDLE);
  assign out_free = !out_valid || out_ready;

  always_comb begin
    case (ph)
      PH_A:    v_cur = item.volt_a;
      PH_B:    v_cur = item.volt_b;
      default: v_cur = item.volt_c;
    endcase
  end

  // duty numerator 256*v + E over denominator 2*E
  assign num_next = $signed({{2{v_cur[VOLT_W-1]}}, v_cur, 8'b0}) + $signed({2'b0, bus_est});
  assign n_ext    = {{6{num_q[25]}}, num_q};
  assign e_ext    = {7'b0, bus_est};
  assign den_full = {bus_est, 1'b0};

  // clamp decision, picks the ratio fed to the shared mul/div
  always_comb begin
    if (bus_est == '0) begin
      if (!v_cur[VOLT_W-1] && v_cur != '0) begin
        num_sel      = CLAMP_HI_NUM;
        den_sel_next = CLAMP_DEN;
      end else if (v_cur[VOLT_W-1]) begin
        num_sel      = CLAMP_LO_NUM;
        den_sel_next = CLAMP_DEN;
      end else begin
        num_sel      = HALF_NUM;
        den_sel_next = HALF_DEN;
      end
    end else if (n50 <= $signed({7'b0, den_full})) begin
      num_sel      = CLAMP_LO_NUM;
      den_sel_next = CLAMP_DEN;
    end else if (n50 >= $signed({1'b0, d49})) begin
      num_sel      = CLAMP_HI_NUM;
      den_sel_next = CLAMP_DEN;
    end else begin
      num_sel      = num_q[MUL_B_W-1:0];
      den_sel_next = den_full;
    end
  end

  assign diff_neg_c = bus_est > target;
  assign diff_mag   = diff_neg_c ? (bus_est - target) : (target - bus_est);

  // floor of alpha*diff/256 is an arithmetic shift of the signed product
  assign step    = filt_p >>> 8;
  assign est_sum = {step[33], step} + $signed({11'b0, bus_est});

  always_comb begin
    if (est_sum[34]) begin
      est_next = '0;
    end else if (|est_sum[33:BUS_W]) begin
      est_next = BUS_MAX;
    end else begin
      est_next = est_sum[BUS_W-1:0];
    end
  end

  always_comb begin
    state_next = state;
    mul_start  = 1'b0;
    div_start  = 1'b0;
    mul_a      = scale;
    mul_b      = num_sel;
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          state_next = in_item.mode ? S_PH_PREP : S_BUS_GO;
        end
      end
      S_BUS_GO: begin
        mul_start  = 1'b1;
        mul_a      = MUL_A_W'(sample_m);
        mul_b      = MUL_B_W'(bus_coeff);
        state_next = S_BUS_WAIT;
      end
      S_BUS_WAIT: begin
        if (mul_done) begin
          state_next = S_FILT_GO;
        end
      end
      S_FILT_GO: begin
        mul_start  = 1'b1;
        mul_a      = MUL_A_W'(alpha_c);
        mul_b      = {1'b0, diff_mag};
        state_next = S_FILT_WAIT;
      end
      S_FILT_WAIT: begin
        if (mul_done) begin
          state_next = S_FILT_ADD;
        end
      end
      S_FILT_ADD: state_next = S_IDLE;
      S_PH_PREP:  state_next = S_PH_SCALE;
      S_PH_SCALE: state_next = S_PH_CLAMP;
      S_PH_CLAMP: begin
        mul_start  = 1'b1;
        state_next = S_PH_MUL_WAIT;
      end
      S_PH_MUL_WAIT: begin
        if (mul_done) begin
          div_start  = 1'b1;
          state_next = S_PH_DIV_WAIT;
        end
      end
      S_PH_DIV_WAIT: begin
        if (div_done) begin
          state_next = (ph == PH_LAST) ? S_OUT : S_PH_PREP;
        end
      end
      S_OUT: begin
        if (out_free) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      filter_alpha  <= ALPHA_RESET;
      bus_coeff     <= COEFF_RESET;
      pwm_period    <= PERIOD_RESET;
      reverse_order <= 1'b0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_FILTER_ALPHA:  filter_alpha  <= cfg_data[8:0];
        REG_BUS_COEFF:     bus_coeff     <= cfg_data;
        REG_PWM_PERIOD:    pwm_period    <= cfg_data;
        REG_REVERSE_ORDER: reverse_order <= cfg_data[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      bus_est <= BUS_RESET;
    end else if (state == S_FILT_ADD) begin
      bus_est <= est_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ph <= PH_A;
    end else if (state == S_IDLE) begin
      ph <= PH_A;
    end else if (state == S_PH_DIV_WAIT && div_done && ph != PH_LAST) begin
      ph <= ph + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      item <= in_item;
    end
    if (state == S_BUS_WAIT && mul_done) begin
      target <= (|mul_prod[PROD_W-1:BUS_W]) ? BUS_MAX : mul_prod[BUS_W-1:0];
    end
    if (state == S_FILT_GO) begin
      diff_neg <= diff_neg_c;
    end
    if (state == S_FILT_WAIT && mul_done) begin
      filt_p <= diff_neg ? -$signed({1'b0, mul_prod[32:0]}) : $signed({1'b0, mul_prod[32:0]});
    end
    if (state == S_PH_PREP) begin
      num_q <= num_next;
    end
    if (state == S_PH_SCALE) begin
      n50 <= (n_ext <<< 5) + (n_ext <<< 4) + (n_ext <<< 1);
      d49 <= (e_ext << 6) + (e_ext << 5) + (e_ext << 1);
    end
    if (state == S_PH_CLAMP) begin
      den_sel <= den_sel_next;
    end
    if (state == S_PH_DIV_WAIT && div_done) begin
      case (ph)
        PH_A:    comp_a <= div_quo[COMPARE_W-1:0];
        PH_B:    comp_b <= div_quo[COMPARE_W-1:0];
        default: comp_c <= div_quo[COMPARE_W-1:0];
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (state == S_OUT && out_free) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_OUT && out_free) begin
      out_item.compare_ch1 <= reverse_order ? comp_c : comp_a;
      out_item.compare_ch2 <= comp_b;
      out_item.compare_ch3 <= reverse_order ? comp_a : comp_c;
    end
  end

`ifndef ASSERT_OFF
  a_out_from_seq: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(state == S_OUT))
    else $error("result appeared outside the output state");

  a_est_update: assert property (@(posedge clk) disable iff (rst)
    !$stable(bus_est) |-> ($past(rst) || $past(state == S_FILT_ADD)))
    else $error("bus estimate changed outside the filter update");

  a_div_owner: assert property (@(posedge clk) disable iff (rst)
    div_done |-> state == S_PH_DIV_WAIT)
    else $error("divider finished while not in use");

  a_one_unit: assert property (@(posedge clk) disable iff (rst)
    !(mul_start && div_start))
    else $error("multiplier and divider started together");
`endif

endmodule
